// ===== design/btfa_pkg.sv =====
// Shared types, constants and an arithmetic helper of the binned tree flow accumulator.
package btfa_pkg;

    localparam int NODE_AW    = 10;
    localparam int LINK_AW    = 12;
    localparam int NODE_DEPTH = 1 << NODE_AW;
    localparam int LINK_DEPTH = 1 << LINK_AW;
    localparam int MAX_BINS   = 7;
    localparam int THRESH_REGS = 6;
    localparam int SUM_W      = 40;
    localparam int VAL_W      = 32;
    localparam int DIST_W     = 32;
    localparam int BIN_W      = 3;
    localparam int MODE_W     = 3;
    localparam int CFG_AW     = 3;
    localparam int CFG_DW     = 32;
    localparam int IN_DW      = 104;
    localparam int OUT_DW     = 48;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam logic [MODE_W-1:0] MODE_CLR_NODES = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DEPOSIT   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PASS      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ACCUM     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ      = 3'd4;
    localparam logic [MODE_W-1:0] MODE_CLR_FLOWS = 3'd5;

    localparam logic [CFG_AW-1:0] REG_BIN_COUNT = 3'd0;
    localparam logic [CFG_AW-1:0] REG_THRESH_0  = 3'd1;
    localparam logic [CFG_AW-1:0] REG_THRESH_5  = 3'd6;

    typedef logic [MAX_BINS-1:0][SUM_W-1:0] row_t;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [NODE_AW-1:0] node;
        logic [NODE_AW-1:0] parent;
        logic               pvalid;
        logic [LINK_AW-1:0] link;
        logic [VAL_W-1:0]   value;
        logic [BIN_W-1:0]   bin;
        logic [BIN_W-1:0]   bidx;
        logic [BIN_W-1:0]   nbins;
        logic               bad;
    } cmd_t;

    // {overflow, saturated sum}
    function automatic logic [SUM_W:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[SUM_W])
            return {1'b1, SUM_MAX};
        return s;
    endfunction

endpackage

// ===== design/btfa_front.sv =====
// Front end: configuration registers, item unpacking and bin classification.
module btfa_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [btfa_pkg::CFG_AW-1:0] cfg_index,
    input  logic [btfa_pkg::CFG_DW-1:0] cfg_data,
    input  logic [btfa_pkg::IN_DW-1:0]  in_data,
    input  logic [btfa_pkg::MODE_W-1:0] in_mode,
    output btfa_pkg::cmd_t              cmd
);
    import btfa_pkg::*;

    logic [BIN_W-1:0]  bin_count_reg;
    logic [DIST_W-1:0] thresh_reg [THRESH_REGS];
    logic [BIN_W-1:0]  nbins;
    logic [DIST_W-1:0] trip_len;
    logic [BIN_W-1:0]  bin;
    logic              found;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_count_reg <= BIN_W'(1);
            for (int i = 0; i < THRESH_REGS; i++)
                thresh_reg[i] <= {DIST_W{1'b1}};
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_BIN_COUNT)
                bin_count_reg <= cfg_data[BIN_W-1:0];
            else if (cfg_index >= REG_THRESH_0 && cfg_index <= REG_THRESH_5)
                thresh_reg[cfg_index - REG_THRESH_0] <= cfg_data;
        end
    end

    assign nbins    = (bin_count_reg == '0) ? BIN_W'(1) : bin_count_reg;
    assign trip_len = in_data[64:33];

    // first bin below the last one in use whose bound covers the distance
    always_comb
    begin
        bin   = nbins - BIN_W'(1);
        found = 1'b0;
        for (int i = 0; i < THRESH_REGS; i++)
        begin
            if (!found && (BIN_W'(i + 1) < nbins) && (trip_len <= thresh_reg[i]))
            begin
                bin   = BIN_W'(i);
                found = 1'b1;
            end
        end
    end

    always_comb
    begin
        cmd.mode   = in_mode;
        cmd.node   = in_data[9:0];
        cmd.parent = in_data[19:10];
        cmd.pvalid = in_data[20];
        cmd.link   = in_data[32:21];
        cmd.value  = in_data[96:65];
        cmd.bidx   = in_data[99:97];
        cmd.bin    = bin;
        cmd.nbins  = nbins;
        cmd.bad    = (in_data[99:97] >= nbins);
    end

endmodule

// ===== design/btfa_queue.sv =====
// Two-entry command queue between front and back end.
module btfa_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  btfa_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output btfa_pkg::cmd_t pop_data
);
    import btfa_pkg::*;

    cmd_t       q_mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = q_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== design/btfa_back.sv =====
// Back end: node and link stores, read-modify-write sequencer and result register.
module btfa_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  btfa_pkg::cmd_t              q_data,
    output logic                        q_pop,
    output logic                        init_busy,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [btfa_pkg::OUT_DW-1:0] out_data
);
    import btfa_pkg::*;

    typedef enum logic [5:0] {
        ST_INIT = 6'b000001,
        ST_IDLE = 6'b000010,
        ST_RDA  = 6'b000100,
        ST_RDB  = 6'b001000,
        ST_RDC  = 6'b010000,
        ST_CLR  = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    cmd_t               cmd_reg;
    logic [LINK_AW-1:0] cnt_reg, cnt_next;
    row_t               row_reg;
    logic               done_pending_reg, done_pending_next;

    row_t               node_mem [NODE_DEPTH];
    row_t               link_mem [LINK_DEPTH];
    row_t               node_q, link_q;
    logic [NODE_AW-1:0] node_raddr;

    logic               node_we, link_we;
    logic [NODE_AW-1:0] node_waddr;
    logic [LINK_AW-1:0] link_waddr;
    row_t               node_wdata, link_wdata;

    row_t               dep_row, sum_row, sum_src;
    logic               dep_sat, sum_sat;
    logic [SUM_W:0]     t;

    logic               out_free, emit;
    logic [SUM_W-1:0]   res_flow;
    logic [BIN_W-1:0]   res_bin;
    logic               res_sat, res_bad;
    logic               out_valid_reg;
    logic [OUT_DW-1:0]  out_data_reg;

    assign out_free  = !out_valid_reg || out_ready;
    assign init_busy = (state_reg == ST_INIT);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign node_raddr = (cmd_reg.mode == MODE_PASS && (state_reg == ST_RDB || state_reg == ST_RDC))
                        ? cmd_reg.parent : cmd_reg.node;

    always_ff @(posedge clk)
    begin
        node_q <= node_mem[node_raddr];
        link_q <= link_mem[cmd_reg.link];
        if (node_we)
            node_mem[node_waddr] <= node_wdata;
        if (link_we)
            link_mem[link_waddr] <= link_wdata;
    end

    // deposit: overwrite with several bins, saturating add with one
    always_comb
    begin
        dep_row = node_q;
        dep_sat = 1'b0;
        t       = '0;
        if (cmd_reg.nbins > BIN_W'(1))
            dep_row[cmd_reg.bin] = SUM_W'(cmd_reg.value);
        else
        begin
            t          = sat_add(node_q[0], SUM_W'(cmd_reg.value));
            dep_row[0] = t[SUM_W-1:0];
            dep_sat    = t[SUM_W];
        end
    end

    // pass adds the saved node row into the parent, accumulate adds the node into the link
    always_comb
    begin
        logic [SUM_W:0] s;
        sum_src = (cmd_reg.mode == MODE_PASS) ? node_q : link_q;
        sum_row = sum_src;
        sum_sat = 1'b0;
        for (int i = 0; i < MAX_BINS; i++)
        begin
            s = sat_add(sum_src[i], (cmd_reg.mode == MODE_PASS) ? row_reg[i] : node_q[i]);
            if (BIN_W'(i) < cmd_reg.nbins)
            begin
                sum_row[i] = s[SUM_W-1:0];
                sum_sat    = sum_sat | s[SUM_W];
            end
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        done_pending_next = done_pending_reg;
        q_pop             = 1'b0;
        node_we           = 1'b0;
        link_we           = 1'b0;
        node_waddr        = cmd_reg.node;
        link_waddr        = cmd_reg.link;
        node_wdata        = dep_row;
        link_wdata        = sum_row;
        emit              = 1'b0;
        res_flow          = '0;
        res_bin           = '0;
        res_sat           = 1'b0;
        res_bad           = 1'b0;
        unique case (state_reg)
            ST_INIT:
            begin
                node_we    = 1'b1;
                link_we    = 1'b1;
                node_waddr = cnt_reg[NODE_AW-1:0];
                link_waddr = cnt_reg;
                node_wdata = '0;
                link_wdata = '0;
                cnt_next   = cnt_reg + LINK_AW'(1);
                if (cnt_reg == {LINK_AW{1'b1}})
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    cnt_next = '0;
                    case (q_data.mode)
                        MODE_CLR_NODES, MODE_CLR_FLOWS:
                        begin
                            done_pending_next = 1'b0;
                            state_next        = ST_CLR;
                        end
                        MODE_DEPOSIT, MODE_PASS, MODE_ACCUM, MODE_READ:
                            state_next = ST_RDA;
                        default:
                        begin
                            done_pending_next = 1'b1;
                            state_next        = ST_CLR;
                        end
                    endcase
                end
            end
            ST_RDA:
                state_next = ST_RDB;
            ST_RDB:
            begin
                case (cmd_reg.mode)
                    MODE_PASS:
                        state_next = ST_RDC;
                    MODE_DEPOSIT:
                    begin
                        res_bin = cmd_reg.bin;
                        res_sat = dep_sat;
                        if (out_free)
                        begin
                            emit       = 1'b1;
                            node_we    = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    MODE_ACCUM:
                    begin
                        res_sat = sum_sat;
                        if (out_free)
                        begin
                            emit       = 1'b1;
                            link_we    = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        res_bad  = cmd_reg.bad;
                        res_flow = cmd_reg.bad ? '0 : link_q[cmd_reg.bidx];
                        if (out_free)
                        begin
                            emit       = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                endcase
            end
            ST_RDC:
            begin
                res_sat    = cmd_reg.pvalid && sum_sat;
                node_waddr = cmd_reg.parent;
                node_wdata = sum_row;
                if (out_free)
                begin
                    emit       = 1'b1;
                    node_we    = cmd_reg.pvalid;
                    state_next = ST_IDLE;
                end
            end
            ST_CLR:
            begin
                if (done_pending_reg)
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    node_waddr = cnt_reg[NODE_AW-1:0];
                    link_waddr = cnt_reg;
                    node_wdata = '0;
                    link_wdata = '0;
                    cnt_next   = cnt_reg + LINK_AW'(1);
                    if (cmd_reg.mode == MODE_CLR_NODES)
                    begin
                        node_we = 1'b1;
                        if (cnt_reg[NODE_AW-1:0] == {NODE_AW{1'b1}})
                            done_pending_next = 1'b1;
                    end
                    else
                    begin
                        link_we = 1'b1;
                        if (cnt_reg == {LINK_AW{1'b1}})
                            done_pending_next = 1'b1;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cmd_reg <= q_data;
        if (state_reg == ST_RDB)
            row_reg <= node_q;
        if (emit)
            out_data_reg <= {3'b000, res_bad, res_sat, res_bin, res_flow};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_INIT;
            cnt_reg          <= '0;
            done_pending_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            done_pending_reg <= done_pending_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

// ===== design/binned_tree_flow_accumulator_core.sv =====
// Top level of the binned tree flow accumulator.
// Keeps seven 40-bit Q32.8 bins per node (1024 nodes) and per link (4096 links), each
// store one 280-bit row per id. Items enter on s_axis with the mode in tuser; the front
// end classifies the deposit distance against the thresholds and queues the command
// (two entries), the back end reads and updates the rows and posts one result on
// m_axis. Pass-to-parent makes two reads through the node store's single read port;
// clear nodes sweeps 1024 rows and clear flows 4096 rows, one row per cycle.
// After reset the block sweeps both stores to zero with s_axis_tready low;
// configuration transfers are taken at any time but must only be made while idle.
// Sums saturate at 2^40-1 and set the saturated flag of that result.
module binned_tree_flow_accumulator_core (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration write channel
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [btfa_pkg::CFG_AW-1:0] cfg_index,
    input  logic [btfa_pkg::CFG_DW-1:0] cfg_data,
    // input stream
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // node_id[9:0], parent_id[19:10], parent_valid[20], link_id[32:21],
    // distance[64:33], value[96:65], bin_index[99:97], zero pad
    input  logic [btfa_pkg::IN_DW-1:0]  s_axis_tdata,
    // mode[2:0]
    input  logic [btfa_pkg::MODE_W-1:0] s_axis_tuser,
    // result stream
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // flow_value[39:0], bin_used[42:40], saturated[43], bad_bin[44], zero pad
    output logic [btfa_pkg::OUT_DW-1:0] m_axis_tdata
);
    import btfa_pkg::*;

    cmd_t cmd_in, cmd_out;
    logic q_full, q_not_empty, q_pop, init_busy, push;

    // no transfer is taken while the reset clearing sweep runs
    assign s_axis_tready = !q_full && !init_busy;
    assign push          = s_axis_tvalid && s_axis_tready;

    btfa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_axis_tdata),
        .in_mode   (s_axis_tuser),
        .cmd       (cmd_in)
    );

    btfa_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (cmd_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (cmd_out)
    );

    btfa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_not_empty),
        .q_data    (cmd_out),
        .q_pop     (q_pop),
        .init_busy (init_busy),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

// ===== design/btfa_checker.sv =====
// Port-level checker for the accumulator core, bound to the top level.
module btfa_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_axis_tready,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [btfa_pkg::OUT_DW-1:0] m_axis_tdata
);
    import btfa_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_bad_no_flow: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[44] |-> m_axis_tdata[39:0] == '0)
        else $error("bad bin read returned a flow");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[44] && (m_axis_tdata[43] || m_axis_tdata[42:40] != '0)))
        else $error("read result carries deposit fields");

    a_sweep_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !s_axis_tready && !m_axis_tvalid)
        else $error("input taken during reset clearing sweep");

endmodule

bind binned_tree_flow_accumulator_core btfa_checker u_btfa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/binned_tree_flow_accumulator_core_checker.sv =====
// Checker for the binned tree flow accumulator: predicts each result and compares it.
`timescale 1ns / 100ps
module binned_tree_flow_accumulator_core_checker
    import btfa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [CFG_AW-1:0]   cfg_index,
    input  logic [CFG_DW-1:0]   cfg_data,
    input  logic                s_axis_tvalid,
    input  logic                s_axis_tready,
    input  logic [IN_DW-1:0]    s_axis_tdata,
    input  logic [MODE_W-1:0]   s_axis_tuser,
    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic [OUT_DW-1:0]   m_axis_tdata,
    output int                  fail_count,
    output int                  pending
);

    typedef struct packed {
        logic             bad;
        logic             sat;
        logic [BIN_W-1:0] bin;
        logic [SUM_W-1:0] flow;
    } flow_result_t;

    logic [SUM_W-1:0]  node_acc [NODE_DEPTH*MAX_BINS];
    logic [SUM_W-1:0]  link_acc [LINK_DEPTH*MAX_BINS];
    logic [2:0]        bins_reg;
    logic [31:0]       thr [THRESH_REGS];
    flow_result_t      expected_q [$];

    assign pending = expected_q.size();

    // saturating add, raises sat on overflow
    function automatic logic [SUM_W-1:0] add_clip(input logic [SUM_W-1:0] a,
                                                  input logic [SUM_W-1:0] b,
                                                  inout logic sat);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[SUM_W])
        begin
            sat = 1'b1;
            return SUM_MAX;
        end
        return s[SUM_W-1:0];
    endfunction

    function automatic flow_result_t predict_flow(input logic [MODE_W-1:0] mode,
                                                  input logic [IN_DW-1:0] d);
        flow_result_t r;
        int unsigned nb;
        int unsigned node;
        int unsigned par;
        int unsigned lnk;
        logic [31:0] trip_len;
        logic [2:0] bidx;
        logic sat;
        r        = '0;
        sat      = 1'b0;
        node     = 32'(d[9:0]);
        par      = 32'(d[19:10]);
        lnk      = 32'(d[32:21]);
        trip_len = d[64:33];
        bidx     = d[99:97];
        nb       = (bins_reg == 0) ? 1 : 32'(bins_reg);
        case (mode)
            MODE_CLR_NODES:
                foreach (node_acc[i]) node_acc[i] = '0;
            MODE_DEPOSIT:
            begin
                r.bin = 3'(nb - 1);
                for (int i = 0; i + 1 < nb && i < THRESH_REGS; i++)
                begin
                    if (trip_len <= thr[i])
                    begin
                        r.bin = 3'(i);
                        break;
                    end
                end
                if (nb > 1)
                    node_acc[node*MAX_BINS + r.bin] = {8'd0, d[96:65]};
                else
                    node_acc[node*MAX_BINS] = add_clip(node_acc[node*MAX_BINS],
                                                       {8'd0, d[96:65]}, sat);
            end
            MODE_PASS:
                if (d[20])
                    for (int i = 0; i < nb; i++)
                        node_acc[par*MAX_BINS + i] = add_clip(node_acc[par*MAX_BINS + i],
                                                              node_acc[node*MAX_BINS + i],
                                                              sat);
            MODE_ACCUM:
                for (int i = 0; i < nb; i++)
                    link_acc[lnk*MAX_BINS + i] = add_clip(link_acc[lnk*MAX_BINS + i],
                                                          node_acc[node*MAX_BINS + i], sat);
            MODE_READ:
                if (bidx >= nb)
                    r.bad = 1'b1;
                else
                    r.flow = link_acc[lnk*MAX_BINS + bidx];
            MODE_CLR_FLOWS:
                foreach (link_acc[i]) link_acc[i] = '0;
            default: ;
        endcase
        r.sat = sat;
        return r;
    endfunction

    task automatic report(input string field, input logic [SUM_W-1:0] exp_v,
                          input logic [SUM_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
            fail_count++;
        end
    endtask

    initial
    begin
        fail_count = 0;
        bins_reg   = 3'd1;
        foreach (thr[i]) thr[i] = '1;
        foreach (node_acc[i]) node_acc[i] = '0;
        foreach (link_acc[i]) link_acc[i] = '0;
    end

    always @(posedge clk)
    begin
        flow_result_t got;
        flow_result_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_BIN_COUNT)
                    bins_reg = cfg_data[2:0];
                else if (cfg_index <= REG_THRESH_5)
                    thr[cfg_index - REG_THRESH_0] = cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_q.insert(expected_q.size(), predict_flow(s_axis_tuser, s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[44:0];
                if (expected_q.size() == 0)
                begin
                    $display("%0t: result with nothing expected, actual %0h", $time, got);
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    report("flow_value", want.flow, got.flow);
                    report("bin_used", want.bin, got.bin);
                    report("saturated", want.sat, got.sat);
                    report("bad_bin", want.bad, got.bad);
                end
            end
        end
    end

endmodule

// ===== tb/binned_tree_flow_accumulator_core_tb.sv =====
// Testbench top for the binned tree flow accumulator: stimulus, idling and verdict.
`timescale 1ns / 100ps
module binned_tree_flow_accumulator_core_tb;
    import btfa_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int PHASE_ITEMS = 316;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CFG_AW-1:0]  cfg_index;
    logic [CFG_DW-1:0]  cfg_data;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [IN_DW-1:0]   s_axis_tdata;
    logic [MODE_W-1:0]  s_axis_tuser;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [OUT_DW-1:0]  m_axis_tdata;
    int                 fail_count;
    int                 pending;

    // idle chances in percent, set per phase
    int                 send_idle;
    int                 recv_idle;
    logic [31:0]        cur_thr [THRESH_REGS];

    binned_tree_flow_accumulator_core u_dut (.*);

    binned_tree_flow_accumulator_core_checker u_chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run guard: far above the slowest legal run, clears and start-up sweep included
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Regression FAIL");
        $finish;
    end

    // receiver side: random back-pressure, decided at the falling edge
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle);

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // one input transfer; tvalid stays high into the next call
    task automatic send_op(input logic [MODE_W-1:0] mode, input int node, input int par,
                           input bit pv, input int lnk, input logic [31:0] trip_len,
                           input logic [31:0] val, input logic [2:0] bidx);
        @(negedge clk);
        while ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {4'd0, bidx, val, trip_len, lnk[11:0], pv, par[9:0], node[9:0]};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic drain;
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic configure(input logic [2:0] nbins, input bit sorted, input bit edges);
        logic [31:0] t [THRESH_REGS];
        foreach (t[i]) t[i] = $urandom;
        if (sorted) t.sort();
        if (edges)
        begin
            t[0] = '0;
            t[THRESH_REGS-1] = '1;
        end
        write_reg(REG_BIN_COUNT, {29'd0, nbins});
        for (int i = 0; i < THRESH_REGS; i++)
        begin
            cur_thr[i] = t[i];
            write_reg(REG_THRESH_0 + CFG_AW'(i), t[i]);
        end
    endtask

    function automatic int pick_node();
        return ($urandom_range(99) < 80) ? $urandom_range(15) : $urandom_range(NODE_DEPTH-1);
    endfunction

    task automatic random_op;
        int w;
        logic [MODE_W-1:0] mode;
        logic [31:0] trip_len;
        logic [31:0] val;
        int lnk;
        int node;
        w = $urandom_range(999);
        if (w < 8)        mode = MODE_CLR_NODES;
        else if (w < 16)  mode = MODE_CLR_FLOWS;
        else if (w < 370) mode = MODE_DEPOSIT;
        else if (w < 570) mode = MODE_PASS;
        else if (w < 770) mode = MODE_ACCUM;
        else if (w < 970) mode = MODE_READ;
        else              mode = 3'($urandom_range(7, 6));
        // distances hug the thresholds so bin edges are hit
        case ($urandom_range(3))
            0: trip_len = cur_thr[$urandom_range(THRESH_REGS-1)];
            1: trip_len = cur_thr[$urandom_range(THRESH_REGS-1)] + 1;
            default: trip_len = $urandom;
        endcase
        val  = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom;
        node = pick_node();
        lnk  = ($urandom_range(99) < 80) ? $urandom_range(7) : $urandom_range(LINK_DEPTH-1);
        // parent equal to node now and then, to double a node towards saturation
        send_op(mode, node, ($urandom_range(9) == 0) ? node : pick_node(),
                $urandom_range(99) < 85, lnk, trip_len, val, 3'($urandom_range(7)));
    endtask

    initial
    begin
        logic [2:0] phase_bins [6] = '{3'd7, 3'd3, 3'd1, 3'd0, 3'd2, 3'd7};
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = MODE_CLR_NODES;
        send_idle     = 32;
        recv_idle     = 71;
        foreach (cur_thr[i]) cur_thr[i] = '1;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset settings, one bin, so deposits add
        send_op(MODE_DEPOSIT, 0, 0, 0, 0, 32'd0, 32'd0, 3'd0);
        send_op(MODE_DEPOSIT, 5, 0, 0, 0, '1, '1, 3'd0);
        send_op(MODE_DEPOSIT, 1023, 0, 0, 0, 32'h8000_0000, '1, 3'd0);
        // parent equal to node doubles; nine passes push past the top
        for (int i = 0; i < 9; i++)
            send_op(MODE_PASS, 5, 5, 1, 0, '0, '0, 3'd0);
        send_op(MODE_PASS, 1023, 5, 0, 0, '0, '0, 3'd0);   // root: no change
        send_op(MODE_PASS, 1023, 6, 1, 0, '0, '0, 3'd0);
        send_op(MODE_ACCUM, 5, 0, 0, 4095, '0, '0, 3'd0);
        send_op(MODE_ACCUM, 5, 0, 0, 4095, '0, '0, 3'd0);
        send_op(MODE_READ, 0, 0, 0, 4095, '0, '0, 3'd0);
        send_op(MODE_READ, 0, 0, 0, 4095, '0, '0, 3'd6);   // bin beyond count
        send_op(MODE_READ, 0, 0, 0, 0, '0, '0, 3'd7);
        send_op(3'd6, 1023, 1023, 1, 4095, '1, '1, 3'd7);
        send_op(3'd7, 0, 0, 0, 0, '0, '0, 3'd0);
        send_op(MODE_CLR_FLOWS, 0, 0, 0, 0, '0, '0, 3'd0);
        send_op(MODE_READ, 0, 0, 0, 4095, '0, '0, 3'd0);
        send_op(MODE_CLR_NODES, 0, 0, 0, 0, '0, '0, 3'd0);
        drain();

        // six phases: first two with sender light / receiver heavy idling,
        // then the reverse, then no idling at all
        for (int p = 0; p < 6; p++)
        begin
            send_idle = (p < 2) ? 32 : (p < 4) ? 71 : 0;
            recv_idle = (p < 2) ? 71 : (p < 4) ? 32 : 0;
            configure(phase_bins[p], p != 4, p == 1 || p == 5);
            for (int i = 0; i < PHASE_ITEMS; i++)
                random_op();
            drain();
        end

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
